@@ design/osm_pkg.sv @@
// Shared types and constants for the order-statistic multiset core.
`default_nettype none
package osm_pkg;

   // Tree geometry and node width
   localparam int INDEX_BITS = 16;
   localparam int COUNT_BITS = 32;

   // Widths used when comparing against fields of fixed size
   localparam int VAL_W = ((INDEX_BITS > 16) ? INDEX_BITS : 16) + 1;
   localparam int CMP_W = (COUNT_BITS > 32) ? COUNT_BITS : 32;

   // First index past the tree
   localparam logic [INDEX_BITS:0] TREE_SIZE = (INDEX_BITS + 1)'(1) << INDEX_BITS;

   // Commands
   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_FIND   = 2'd2;

   // Status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_RANK  = 2'd1;
   localparam logic [1:0] STAT_VALUE = 2'd2;

   // Request payload
   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] value;
      logic [31:0] rank;
   } osm_req_type;

   // Response payload
   typedef struct packed {
      logic [15:0] found_value;
      logic [31:0] total_count;
      logic [1:0]  status;
   } osm_rsp_type;

   // Tree memory write port
   typedef struct packed {
      logic                  en;
      logic [INDEX_BITS-1:0] addr;
      logic [COUNT_BITS-1:0] data;
   } osm_wr_type;

endpackage
`default_nettype wire

@@ design/osm_tree_ram.sv @@
// Fenwick node memory: one write port, one read port with registered data.
`default_nettype none
module osm_tree_ram
   import osm_pkg::*;
(
   input  wire logic                  clock,
   input  wire osm_wr_type            wr,
   input  wire logic [INDEX_BITS-1:0] rd_addr,
   output logic      [COUNT_BITS-1:0] rd_data
);

   logic [COUNT_BITS-1:0] mem [2**INDEX_BITS];

   // Write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Read port, registered data
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

@@ design/order_statistic_multiset_core.sv @@
// Order-statistic multiset core: Fenwick tree of counts held in one memory.
//
// Usage. Requests (command, value, rank) enter on req_valid/req_stall; one
// response (found_value, total_count, status) leaves per request on
// rsp_valid/rsp_stall. A transaction completes on a clock edge where valid
// is high and stall is low.
// Sequence per request: an insert walks the update chain of at most
// INDEX_BITS nodes; a find descends the tree, one descent step per cycle;
// a remove descends, then walks the update chain; a rejected request goes
// straight to the done state.
// One request is worked on at a time; the next is taken once the previous one
// has reached the response register and the block is idle again. Every
// descent step is one read of the tree memory; every update step is one read
// and one write of the single tree memory port pair.
// Reset: synchronous, active high. After reset the block sweeps all
// 2**INDEX_BITS (65536) nodes to zero, one node per cycle, with req_stall
// high; the element count is zero.
// When the receiver stalls, the response register holds; one more request
// can be taken and worked, it then waits for the register with req_stall high.
`default_nettype none
module order_statistic_multiset_core
   import osm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire osm_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output osm_rsp_type      rsp_data
);

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_SEL_RD = 7'b0000100,
      ST_SEL    = 7'b0001000,
      ST_UPD_RD = 7'b0010000,
      ST_UPD    = 7'b0100000,
      ST_DONE   = 7'b1000000
   } osm_state_type;

   osm_state_type         state_ff, state_in;
   logic [INDEX_BITS-1:0] clr_addr_ff, clr_addr_in;
   logic [INDEX_BITS:0]   pos_ff, pos_in;
   logic [INDEX_BITS-1:0] step_ff, step_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [COUNT_BITS-1:0] total_ff, total_in;
   logic [INDEX_BITS-1:0] found_ff, found_in;
   logic [1:0]            status_ff, status_in;
   logic                  up_ff, up_in;
   logic                  remove_ff, remove_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   osm_rsp_type           rsp_data_ff, rsp_data_in;

   osm_wr_type            tree_wr;
   logic [INDEX_BITS-1:0] tree_rd_addr;
   logic [COUNT_BITS-1:0] tree_rd_data;

   logic                  req_take;
   logic                  value_bad;
   logic                  rank_bad;
   logic [INDEX_BITS-1:0] cand;
   logic                  take;
   logic [INDEX_BITS-1:0] sel_pos;
   logic [INDEX_BITS-1:0] sel_step;
   logic [INDEX_BITS:0]   upd_next;

   osm_tree_ram u_tree (
      .clock   (clock),
      .wr      (tree_wr),
      .rd_addr (tree_rd_addr),
      .rd_data (tree_rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Request checks
   assign value_bad = (req_data.value == 16'd0)
                   || (VAL_W'(req_data.value) >= VAL_W'(TREE_SIZE))
                   || (total_ff == {COUNT_BITS{1'b1}});
   assign rank_bad  = (req_data.rank == 32'd0)
                   || (CMP_W'(req_data.rank) > CMP_W'(total_ff));

   // Descent step: node data for pos + step is on the read port
   assign cand     = pos_ff[INDEX_BITS-1:0] + step_ff;
   assign take     = (tree_rd_data < rem_ff);
   assign sel_pos  = take ? cand : pos_ff[INDEX_BITS-1:0];
   assign sel_step = step_ff >> 1;

   // Update chain: add lowest set bit
   assign upd_next = pos_ff + (pos_ff & (~pos_ff + (INDEX_BITS + 1)'(1)));

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      pos_in       = pos_ff;
      step_in      = step_ff;
      rem_in       = rem_ff;
      total_in     = total_ff;
      found_in     = found_ff;
      status_in    = status_ff;
      up_in        = up_ff;
      remove_in    = remove_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      tree_wr.en   = 1'b0;
      tree_wr.addr = pos_ff[INDEX_BITS-1:0];
      tree_wr.data = up_ff ? tree_rd_data + COUNT_BITS'(1)
                           : tree_rd_data - COUNT_BITS'(1);
      tree_rd_addr = pos_ff[INDEX_BITS-1:0];

      unique case (state_ff)
         ST_CLEAR: begin
            tree_wr.en   = 1'b1;
            tree_wr.addr = clr_addr_ff;
            tree_wr.data = '0;
            clr_addr_in  = clr_addr_ff + INDEX_BITS'(1);
            if (clr_addr_ff == {INDEX_BITS{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               found_in  = '0;
               status_in = STAT_OK;
               case (req_data.command)
                  CMD_INSERT: begin
                     if (value_bad) begin
                        status_in = STAT_VALUE;
                        state_in  = ST_DONE;
                     end else begin
                        pos_in   = (INDEX_BITS + 1)'(req_data.value);
                        up_in    = 1'b1;
                        state_in = ST_UPD_RD;
                     end
                  end
                  default: begin
                     // remove, find; the unused code acts as find
                     remove_in = (req_data.command == CMD_REMOVE);
                     if (rank_bad) begin
                        status_in = STAT_RANK;
                        state_in  = ST_DONE;
                     end else begin
                        pos_in   = '0;
                        step_in  = INDEX_BITS'(1) << (INDEX_BITS - 1);
                        rem_in   = COUNT_BITS'(req_data.rank);
                        state_in = ST_SEL_RD;
                     end
                  end
               endcase
            end
         end
         ST_SEL_RD: begin
            tree_rd_addr = cand;
            state_in     = ST_SEL;
         end
         ST_SEL: begin
            pos_in       = {1'b0, sel_pos};
            step_in      = sel_step;
            tree_rd_addr = sel_pos + sel_step;
            if (take) begin
               rem_in = rem_ff - tree_rd_data;
            end
            if (sel_step == '0) begin
               found_in = sel_pos + INDEX_BITS'(1);
               if (remove_ff) begin
                  pos_in   = {1'b0, sel_pos + INDEX_BITS'(1)};
                  up_in    = 1'b0;
                  state_in = ST_UPD_RD;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_UPD_RD: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            // write back this node, read the next one on the chain
            tree_wr.en   = 1'b1;
            pos_in       = upd_next;
            tree_rd_addr = upd_next[INDEX_BITS-1:0];
            if (upd_next[INDEX_BITS]) begin
               total_in = up_ff ? total_ff + COUNT_BITS'(1)
                                : total_ff - COUNT_BITS'(1);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.found_value = 16'(found_ff);
               rsp_data_in.total_count = 32'(total_ff);
               rsp_data_in.status      = status_ff;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers
   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      step_ff     <= step_in;
      rem_ff      <= rem_in;
      found_ff    <= found_in;
      status_ff   <= status_in;
      up_ff       <= up_in;
      remove_ff   <= remove_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Memory is written only by the clearing sweep or the update chain
   assert property (@(posedge clock) disable iff (reset)
      tree_wr.en |-> (state_ff == ST_CLEAR || state_ff == ST_UPD))
      else $error("tree written outside clear or update");

   // Element count moves by at most one per transaction
   assert property (@(posedge clock) disable iff (reset)
      !$stable(total_ff) |-> (total_ff == $past(total_ff) + COUNT_BITS'(1)
                           || total_ff == $past(total_ff) - COUNT_BITS'(1)))
      else $error("element count jumped");

   // A rejected transaction reports no element
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STAT_OK) |-> (rsp_data.found_value == 16'd0))
      else $error("rejected response carries a value");

   // No response is loaded while the response register is stalled
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response overwritten");

endmodule
`default_nettype wire

@@ verif/osm_checker.sv @@
`timescale 1ns / 1ps
// Response checker for the order-statistic multiset core: shadow Fenwick tree and compare.
module osm_checker
   import osm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire osm_req_type       req_data,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire osm_rsp_type       rsp_data,
   output int                     fail_count,
   output int                     outstanding,
   output logic [COUNT_BITS-1:0]  held_count,
   output int                     responses_checked,
   output int                     selections,
   output int                     rejections
);

   localparam int unsigned NODES = 1 << INDEX_BITS;

   // Shadow copy of the count tree and the element total
   logic [COUNT_BITS-1:0] tally [NODES];
   logic [COUNT_BITS-1:0] held_total;
   osm_rsp_type           expected_rsps [$];

   // Add or subtract one along the lowest-set-bit chain starting at node
   function automatic void bump_chain(int unsigned node, bit up);
      while (node < NODES) begin
         tally[node] = up ? tally[node] + 1'b1 : tally[node] - 1'b1;
         node += node & (~node + 1);
      end
   endfunction

   // Top-down descent: smallest value whose prefix count reaches want
   function automatic int unsigned select_rank(logic [31:0] want);
      int unsigned     pos;
      int unsigned     nxt;
      int unsigned     step;
      longint unsigned rem;
      pos = 0;
      rem = want;
      for (step = NODES >> 1; step != 0; step >>= 1) begin
         nxt = pos + step;
         if (nxt < NODES && longint'(tally[nxt]) < rem) begin
            pos = nxt;
            rem -= tally[nxt];
         end
      end
      return pos + 1;
   endfunction

   // Apply one command to the shadow set and return the response it should give
   function automatic osm_rsp_type apply_command(osm_req_type cmd);
      osm_rsp_type res;
      int unsigned pick;
      res = '0;
      res.status = STAT_OK;
      if (cmd.command == CMD_INSERT) begin
         if (cmd.value == '0 || int'(cmd.value) >= NODES || held_total == '1) begin
            res.status = STAT_VALUE;
         end else begin
            bump_chain(cmd.value, 1'b1);
            held_total = held_total + 1'b1;
         end
      end else if (cmd.rank == '0 || 64'(cmd.rank) > 64'(held_total)) begin
         res.status = STAT_RANK;
      end else begin
         // find, remove and the spare code all select; only remove deletes
         pick = select_rank(cmd.rank);
         res.found_value = 16'(pick);
         if (cmd.command == CMD_REMOVE) begin
            bump_chain(pick, 1'b0);
            held_total = held_total - 1'b1;
         end
      end
      res.total_count = 32'(held_total);
      return res;
   endfunction

   // Compare the response transaction first, then predict the request transaction
   always @(posedge clock) begin
      osm_rsp_type want;
      if (reset) begin
         foreach (tally[i]) tally[i] = '0;
         held_total = '0;
         expected_rsps.delete();
         fail_count = 0;
         responses_checked = 0;
         selections = 0;
         rejections = 0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (expected_rsps.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("[%0t] unexpected response: value %h count %0d status %0d",
                           $realtime, rsp_data.found_value, rsp_data.total_count,
                           rsp_data.status);
            end else begin
               want = expected_rsps.pop_front();
               responses_checked++;
               if (rsp_data.found_value !== want.found_value ||
                   rsp_data.total_count !== want.total_count ||
                   rsp_data.status !== want.status) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("[%0t] response %0d expected value %h count %0d status %0d",
                              $realtime, responses_checked, want.found_value,
                              want.total_count, want.status);
                     $display("   got value %h count %0d status %0d",
                              rsp_data.found_value, rsp_data.total_count,
                              rsp_data.status);
                  end
               end
            end
         end
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            want = apply_command(req_data);
            if (want.status != STAT_OK)
               rejections++;
            else if (req_data.command != CMD_INSERT)
               selections++;
            expected_rsps.push_back(want);
         end
      end
      outstanding = expected_rsps.size();
      held_count = held_total;
   end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Top-level testbench for the order-statistic multiset core: stimulus, stalls and verdict.
module testbench
   import osm_pkg::*;
();

   localparam logic [1:0] CMD_SPARE     = 2'd3;   // unused code, acts as find
   localparam int         RANDOM_ITEMS  = 1130;
   localparam int         TAIL_CYCLES   = 40;
   localparam int         CYCLE_LIMIT   = 1_000_000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   osm_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   osm_rsp_type rsp_data;

   int                    fail_count;
   int                    outstanding;
   logic [COUNT_BITS-1:0] held_count;
   int                    responses_checked;
   int                    selections;
   int                    rejections;

   int cycle_count = 0;
   int n_sent = 0;
   bit quiet_req = 1'b0;
   bit quiet_rsp = 1'b0;

   order_statistic_multiset_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   osm_checker rsp_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data          (req_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_data          (rsp_data),
      .fail_count        (fail_count),
      .outstanding       (outstanding),
      .held_count        (held_count),
      .responses_checked (responses_checked),
      .selections        (selections),
      .rejections        (rejections)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d responses outstanding",
                  cycle_count, outstanding);
         $display("FAIL");
         $finish;
      end
   end

   function automatic osm_req_type build_req(logic [1:0] op, logic [15:0] val,
                                             logic [31:0] k);
      osm_req_type r;
      r.command = op;
      r.value = val;
      r.rank = k;
      return r;
   endfunction

   // Random command against the current set size; keeps the set in the low hundreds
   function automatic osm_req_type draw_request(logic [COUNT_BITS-1:0] count);
      osm_req_type r;
      int          roll;
      int          pick;
      int          ins_cut;
      r.value = 16'($urandom());
      r.rank = $urandom();
      ins_cut = (count > 150) ? 20 : ((count < 5) ? 60 : 40);
      roll = $urandom_range(0, 99);
      if (roll < ins_cut) begin
         r.command = CMD_INSERT;
         pick = $urandom_range(0, 9);
         if (pick == 0)
            r.value = '0;
         else if (pick == 1)
            r.value = 16'hFFF0 + 16'($urandom_range(0, 15));
         else if (pick < 6)
            r.value = 16'($urandom_range(1, 15));
         else
            r.value = 16'($urandom_range(1, 65535));
      end else begin
         if (roll < ins_cut + 30)
            r.command = CMD_REMOVE;
         else
            r.command = ($urandom_range(0, 3) == 0) ? CMD_SPARE : CMD_FIND;
         pick = $urandom_range(0, 19);
         if (pick == 0)
            r.rank = '0;
         else if (pick == 1)
            r.rank = 32'(count) + 1;
         else if (pick == 2)
            r.rank = $urandom();
         else if (pick == 3)
            r.rank = 32'(count);
         else if (pick == 4 || count == 0)
            r.rank = 32'd1;
         else
            r.rank = $urandom_range(1, 32'(count));
      end
      return r;
   endfunction

   // Present one request transaction after a random gap and hold it until taken
   task automatic issue_request(input osm_req_type item);
      int gap;
      gap = quiet_req ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      @(negedge clock);
      n_sent++;
   endtask

   // Hold off the sender until every response is back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
   endtask

   // Receiver: random stall before each response transaction
   initial begin
      int gap;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         gap = quiet_rsp ? 0 : $urandom_range(0, 15);
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   // Stimulus and verdict
   initial begin
      int n;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty set, zero value, extremes of value and rank
      issue_request(build_req(CMD_FIND,   16'h0000, 32'd1));
      issue_request(build_req(CMD_REMOVE, 16'h0000, 32'd1));
      issue_request(build_req(CMD_INSERT, 16'h0000, 32'd0));
      issue_request(build_req(CMD_INSERT, 16'hFFFF, 32'hFFFF_FFFF));
      issue_request(build_req(CMD_INSERT, 16'h0001, 32'd0));
      issue_request(build_req(CMD_INSERT, 16'h0001, 32'd0));
      issue_request(build_req(CMD_INSERT, 16'h8000, 32'd0));
      issue_request(build_req(CMD_INSERT, 16'h5555, 32'd0));
      issue_request(build_req(CMD_INSERT, 16'hAAAA, 32'd0));
      issue_request(build_req(CMD_FIND,   16'hFFFF, 32'd0));
      issue_request(build_req(CMD_FIND,   16'h0000, 32'hFFFF_FFFF));
      issue_request(build_req(CMD_REMOVE, 16'h0000, 32'd7));
      issue_request(build_req(CMD_FIND,   16'h0000, 32'd1));
      issue_request(build_req(CMD_FIND,   16'h0000, 32'd6));
      issue_request(build_req(CMD_SPARE,  16'h0000, 32'd3));
      issue_request(build_req(CMD_SPARE,  16'h0000, 32'd0));
      // drain the set from both ends down to empty
      issue_request(build_req(CMD_REMOVE, 16'h0000, 32'd6));
      issue_request(build_req(CMD_REMOVE, 16'h0000, 32'd1));
      issue_request(build_req(CMD_FIND,   16'h0000, 32'd4));
      issue_request(build_req(CMD_REMOVE, 16'h0000, 32'd4));
      issue_request(build_req(CMD_REMOVE, 16'h0000, 32'd1));
      issue_request(build_req(CMD_REMOVE, 16'h0000, 32'd1));
      issue_request(build_req(CMD_REMOVE, 16'h0000, 32'd1));
      issue_request(build_req(CMD_FIND,   16'h0000, 32'd1));
      wait_for_drain();

      // random traffic; idling style changes every 50 items, periodic full drains
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 50 == 0) begin
            quiet_req = ($urandom_range(0, 3) == 0);
            quiet_rsp = ($urandom_range(0, 3) == 0);
         end
         if (n % 250 == 249)
            wait_for_drain();
         issue_request(draw_request(held_count));
      end

      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Sent %0d requests, checked %0d responses: %0d rank selections, %0d rejected.",
               n_sent, responses_checked, selections, rejections);
      $display("Covered empty-set and boundary ranks, zero and top values, all command codes.");
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
